### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// assertion on the default clk_i / rst_ni pair
`define ASSERT_STD(name, prop, msg) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

### rtl/tfct_pkg.sv
// package for the three-frame codon translator: types, constants, lookups
`timescale 1ns / 1ps

package tfct_pkg;

  localparam logic [7:0] LineWidthReset = 8'd60;
  localparam logic [7:0] UpperLimit     = 8'd90;
  localparam logic [7:0] CaseOffset     = 8'd32;
  localparam logic [7:0] CharUnknown    = 8'h58;  // 'X'
  localparam logic [7:0] CharA          = 8'h41;
  localparam logic [7:0] CharC          = 8'h43;
  localparam logic [7:0] CharG          = 8'h47;
  localparam logic [7:0] CharT          = 8'h54;
  localparam int unsigned NumFrames     = 3;

  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  // standard genetic code, index b1*16 + b2*4 + b3, leftmost letter is index 0
  localparam logic [511:0] GenCode =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

  typedef struct packed {
    logic       known;
    logic [1:0] code;
  } base_t;

  function automatic base_t base_decode(logic [7:0] c);
    base_t b;
    b.known = 1'b1;
    b.code  = CodeA;
    case (c)
      CharA:   b.code = CodeA;
      CharC:   b.code = CodeC;
      CharG:   b.code = CodeG;
      CharT:   b.code = CodeT;
      default: b.known = 1'b0;
    endcase
    return b;
  endfunction

endpackage

### rtl/tfct_ifs.sv
// valid/ready channel interfaces of the codon translator
`timescale 1ns / 1ps

interface tfct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       seq_start;
  modport source (output valid, base_char, seq_start, input ready);
  modport sink   (input valid, base_char, seq_start, output ready);
endinterface

interface tfct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] amino_char;
  logic [1:0] frame;
  logic       line_end;
  modport source (output valid, amino_char, frame, line_end, input ready);
  modport sink   (input valid, amino_char, frame, line_end, output ready);
endinterface

interface tfct_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_width;
  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

### rtl/tfct_codon.sv
// codon lookup: three decoded bases to a one-letter amino acid
`timescale 1ns / 1ps

module tfct_codon import tfct_pkg::*; (
  input  base_t      b1_i,
  input  base_t      b2_i,
  input  base_t      b3_i,
  output logic [7:0] amino_o
);

  logic [5:0] idx;

  assign idx = {b1_i.code, b2_i.code, b3_i.code};

  always_comb begin
    if (b1_i.known && b2_i.known && b3_i.known) begin
      amino_o = GenCode[9'd8 * (9'd63 - {3'd0, idx}) +: 8];
    end else begin
      amino_o = CharUnknown;
    end
  end

endmodule

### rtl/three_frame_codon_translator_top.sv
// top level of the three-frame codon translator
// a result item is registered and shown in the cycle after the base that completes its codon is accepted
// throughput: one base item per cycle while no result item is stalled, set by the single result register
// the input stalls only while a result item waits and the output is not ready
// reset: line width 60, base history, phase and frame counts cleared, no result pending
`timescale 1ns / 1ps

module three_frame_codon_translator_top import tfct_pkg::*; #(
  parameter logic [7:0] LineWidthInit = LineWidthReset
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfct_in_if.sink   in_i,
  tfct_out_if.source out_o,
  tfct_cfg_if.sink  cfg_i
);

  logic [7:0] line_width_q;
  base_t      prev0_q, prev1_q;
  logic [1:0] seen_q;
  logic [1:0] phase_q;
  logic [7:0] count_q [NumFrames];

  logic       out_valid_q;
  logic [7:0] amino_q;
  logic [1:0] frame_q;
  logic       line_end_q;

  logic       accept;
  logic       start;
  logic [7:0] char_red;
  base_t      cur_base;
  base_t      prev0_eff, prev1_eff;
  logic [1:0] seen_eff;
  logic [1:0] phase_eff;
  logic [1:0] fr;
  logic       emit;
  logic [7:0] count_cur;
  logic [7:0] count_inc;
  logic       le;
  logic [7:0] amino;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign start       = in_i.seq_start;

  assign char_red  = (in_i.base_char > UpperLimit) ? in_i.base_char - CaseOffset
                                                   : in_i.base_char;
  assign cur_base  = base_decode(char_red);

  // a sequence start acts as if the state were cleared just before this base
  assign seen_eff  = start ? 2'd0 : seen_q;
  assign phase_eff = start ? 2'd0 : phase_q;
  assign prev0_eff = start ? base_t'('0) : prev0_q;
  assign prev1_eff = start ? base_t'('0) : prev1_q;

  assign emit = (seen_eff == 2'd2);
  // codon began two bases back
  assign fr   = (phase_eff == 2'd2) ? 2'd0 : phase_eff + 2'd1;

  always_comb begin
    count_cur = '0;
    for (int i = 0; i < NumFrames; i++) begin
      if (fr == i[1:0]) begin
        count_cur = count_q[i];
      end
    end
    if (start) begin
      count_cur = '0;
    end
  end

  assign count_inc = count_cur + 8'd1;
  assign le        = (count_inc == line_width_q);

  tfct_codon u_codon (
    .b1_i    (prev1_eff),
    .b2_i    (prev0_eff),
    .b3_i    (cur_base),
    .amino_o (amino)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthInit;
    end else if (cfg_i.valid) begin
      line_width_q <= cfg_i.line_width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev0_q <= '0;
      prev1_q <= '0;
      seen_q  <= '0;
      phase_q <= '0;
      for (int i = 0; i < NumFrames; i++) begin
        count_q[i] <= '0;
      end
    end else if (accept) begin
      prev1_q <= prev0_eff;
      prev0_q <= cur_base;
      seen_q  <= emit ? 2'd2 : seen_eff + 2'd1;
      phase_q <= (phase_eff == 2'd2) ? 2'd0 : phase_eff + 2'd1;
      for (int i = 0; i < NumFrames; i++) begin
        if (emit && fr == i[1:0]) begin
          count_q[i] <= le ? 8'd0 : count_inc;
        end else if (start) begin
          count_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      amino_q    <= amino;
      frame_q    <= fr;
      line_end_q <= le;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.amino_char = amino_q;
  assign out_o.frame      = frame_q;
  assign out_o.line_end   = line_end_q;

endmodule

### rtl/tfct_checker.sv
// port-level assertions for the codon translator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_seq_start_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_amino_i,
  input logic [1:0] out_frame_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result item holds its payload
  `ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_amino_i) && $stable(out_frame_i), "stalled result item changed")

  // a new result item follows an accepted input item
  `ASSERT_STD(a_out_cause, out_valid_i && !$past(out_valid_i) |-> $past(in_acc), "result item without input item")

  // the first base of a sequence never completes a codon
  `ASSERT_STD(a_start_silent, in_acc && in_seq_start_i |=> !out_valid_i, "result item on sequence start")

  // an empty output register never blocks the input
  `ASSERT_STD(a_ready_empty, !out_valid_i |-> in_ready_i, "input stalled with empty output")

  `ASSERT_STD(a_frame_range, out_valid_i |-> out_frame_i != 2'd3, "frame out of range")

endmodule

bind three_frame_codon_translator_top tfct_checker u_tfct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_seq_start_i (in_i.seq_start),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_amino_i    (out_o.amino_char),
  .out_frame_i    (out_o.frame)
);

### verif/tb.sv
// testbench for the three-frame codon translator: random and directed bases, scoreboard
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0] amino;
    logic [1:0] frame;
    logic       line_end;
  } residue_t;

  typedef enum logic [1:0] {NucA, NucC, NucG, NucT} nuc_e;

  localparam logic [7:0] ChA          = "A";
  localparam logic [7:0] ChC          = "C";
  localparam logic [7:0] ChG          = "G";
  localparam logic [7:0] ChT          = "T";
  localparam logic [7:0] ChN          = "N";
  localparam logic [7:0] ChUnknown    = "X";
  localparam logic [7:0] FoldLimit    = 8'd90;
  localparam logic [7:0] LowerShift   = 8'd32;
  localparam logic [7:0] DefaultWidth = 8'd60;
  localparam int unsigned SettleCycles = 3;

  // codon table, index n1*16 + n2*4 + n3, entry 0 is the leftmost letter
  localparam logic [0:63][7:0] AminoTable =
    "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tfct_in_if  in_if ();
  tfct_out_if out_if ();
  tfct_cfg_if cfg_if ();

  three_frame_codon_translator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // translator state as predicted
  logic [7:0]  width_model;
  logic [7:0]  hist_newest;
  logic [7:0]  hist_older;
  int unsigned history_len;
  logic [1:0]  phase_model;
  logic [7:0]  frame_count [3];

  residue_t    expected_residues [$];
  int unsigned error_count;
  int          hold_off_cycles;
  bit          quiet_tail;

  function automatic bit nuc_of(input logic [7:0] c, output nuc_e n);
    n = NucA;
    case (c)
      ChA: n = NucA;
      ChC: n = NucC;
      ChG: n = NucG;
      ChT: n = NucT;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [7:0] codon_letter(input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3);
    nuc_e n1, n2, n3;
    bit   ok;
    ok = nuc_of(b1, n1) & nuc_of(b2, n2) & nuc_of(b3, n3);
    if (!ok) return ChUnknown;
    return AminoTable[{n1, n2, n3}];
  endfunction

  // advances the predicted state by one base, returns 1 when a residue comes out
  function automatic bit predict_residue(input logic [7:0] raw, input bit start,
                                         output residue_t r);
    logic [7:0] c;
    logic [1:0] fr;
    logic [7:0] cnt;
    bit         emitted;
    emitted = 1'b0;
    r = '0;
    if (start) begin
      hist_newest = '0;
      hist_older  = '0;
      history_len = 0;
      phase_model = '0;
      foreach (frame_count[i]) frame_count[i] = '0;
    end
    c = (raw > FoldLimit) ? raw - LowerShift : raw;
    if (history_len >= 2) begin
      // codon began two bases back
      fr = (phase_model == 2'd2) ? 2'd0 : phase_model + 2'd1;
      cnt = frame_count[fr] + 8'd1;
      r.amino    = codon_letter(hist_older, hist_newest, c);
      r.frame    = fr;
      r.line_end = (cnt == width_model);
      if (r.line_end) cnt = '0;
      frame_count[fr] = cnt;
      emitted = 1'b1;
    end else begin
      history_len++;
    end
    hist_older  = hist_newest;
    hist_newest = c;
    phase_model = (phase_model == 2'd2) ? 2'd0 : phase_model + 2'd1;
    return emitted;
  endfunction

  function automatic logic [7:0] random_base();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: c = ChA;
      1: c = ChC;
      2: c = ChG;
      default: c = ChT;
    endcase
    if ($urandom_range(0, 1) == 1) c = c + LowerShift;
    return c;
  endfunction

  function automatic void report_residue(input string what, input residue_t want_r,
                                         input residue_t got_r);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected amino %h frame %0d line_end %0b, %s %h frame %0d line_end %0b",
               $time, what, want_r.amino, want_r.frame, want_r.line_end,
               "got amino", got_r.amino, got_r.frame, got_r.line_end);
  endfunction

  task automatic send_base(input logic [7:0] c, input bit start);
    residue_t r;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.base_char <= c;
    in_if.seq_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    if (predict_residue(c, start, r)) expected_residues.push_back(r);
  endtask

  task automatic idle_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 16));
  endtask

  // stops offering bases until every pending residue has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_residues.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_line_width(input logic [7:0] w);
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.line_width <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    width_model = w;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // reset width, case folding, stops, unknown bytes, restarts
  task automatic test_directed_bases();
    send_base(ChA, 1'b1);
    send_base(ChT, 1'b0);
    send_base(ChG, 1'b0);
    send_base(ChA + LowerShift, 1'b0);
    send_base(ChA + LowerShift, 1'b0);
    send_base(ChT + LowerShift, 1'b0);
    send_base(ChA + LowerShift, 1'b0);
    send_base(ChG + LowerShift, 1'b0);
    send_base(ChN, 1'b0);
    send_base(8'h5A, 1'b0);
    send_base(8'h5B, 1'b0);
    send_base(8'h00, 1'b0);
    send_base(8'hFF, 1'b0);
    send_base(8'h80, 1'b0);
    send_base(8'h7B, 1'b0);
    send_base(ChT + LowerShift, 1'b1);
    send_base(ChG, 1'b0);
    send_base(ChA, 1'b0);
    send_base(ChC + LowerShift, 1'b1);
    send_base(ChC, 1'b1);
    send_base(ChC + LowerShift, 1'b1);
    send_base(ChG, 1'b0);
    send_base(ChT, 1'b0);
    send_base(ChA, 1'b0);
    send_base(ChA + LowerShift, 1'b0);
  endtask

  // short sequences at narrow, wide and random line widths
  task automatic test_line_widths();
    logic [7:0] widths [4];
    int         len;
    widths = '{8'd1, 8'd3, 8'd255, 8'($urandom_range(2, 254))};
    foreach (widths[i]) begin
      wait_drained();
      write_line_width(widths[i]);
      repeat (3) begin
        len = $urandom_range(3, 14);
        for (int k = 0; k < len; k++) begin
          maybe_gap();
          send_base(random_base(), (k == 0) || ($urandom_range(0, 31) == 0));
        end
      end
    end
  endtask

  // width dropped to zero below running counts: counts wrap at 256 and flag there
  task automatic test_count_wrap();
    wait_drained();
    write_line_width(8'd200);
    for (int k = 0; k < 90; k++) begin
      maybe_gap();
      send_base(random_base(), k == 0);
    end
    wait_drained();
    write_line_width(8'd0);
    @(posedge clk_i);
    hold_off_cycles = 300;
    repeat (690) begin
      maybe_gap();
      send_base(random_base(), 1'b0);
    end
  endtask

  // back-to-back traffic with both sides always ready
  task automatic test_quiet_tail();
    wait_drained();
    quiet_tail = 1'b1;
    write_line_width(DefaultWidth);
    for (int k = 0; k < 45; k++)
      send_base(random_base(), (k == 0) || ($urandom_range(0, 15) == 0));
  endtask

  initial begin : residue_sink
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0 && !quiet_tail) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : residue_check
    residue_t got_r;
    residue_t want_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_r.amino    = out_if.amino_char;
      got_r.frame    = out_if.frame;
      got_r.line_end = out_if.line_end;
      if (expected_residues.size() == 0) begin
        report_residue("residue with none pending", '0, got_r);
      end else begin
        want_r = expected_residues.pop_front();
        if (got_r.amino !== want_r.amino || got_r.frame !== want_r.frame ||
            got_r.line_end !== want_r.line_end)
          report_residue("residue mismatch", want_r, got_r);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : run
    in_if.valid       = 1'b0;
    in_if.base_char   = '0;
    in_if.seq_start   = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.line_width = '0;
    quiet_tail        = 1'b0;
    hold_off_cycles   = 0;
    error_count       = 0;
    width_model       = DefaultWidth;
    hist_newest       = '0;
    hist_older        = '0;
    history_len       = 0;
    phase_model       = '0;
    foreach (frame_count[i]) frame_count[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_bases();
    test_line_widths();
    test_count_wrap();
    test_quiet_tail();
    wait_drained();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tfct_pkg.sv
rtl/tfct_ifs.sv
rtl/tfct_codon.sv
rtl/three_frame_codon_translator_top.sv
rtl/tfct_checker.sv
verif/tb.sv
